@@ rtl/cfs_pkg.sv @@
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants for the closest fraction search block:
// request and result payloads, sequencer states and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package cfs_pkg;

	// field widths of the request and result payloads
	localparam int FIELD_BITS     = 16;
	localparam int NUM_OUT_BITS   = 32;
	localparam int VALUE_BITS_DEF = 16;

	// query request: target fraction and denominator limit
	typedef struct packed {
		logic [FIELD_BITS-1:0] target_num;
		logic [FIELD_BITS-1:0] target_den;
		logic [FIELD_BITS-1:0] den_limit;
	} query_t;

	// result payload: nearest fraction
	typedef struct packed {
		logic [NUM_OUT_BITS-1:0] best_num;
		logic [FIELD_BITS-1:0]   best_den;
	} result_t;

	// search sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LO_A,
		ST_LO_B,
		ST_HI_A,
		ST_HI_B,
		ST_STEP,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

@@ rtl/closest_fraction_search.sv @@
// ----------------------------------------------------------------------------
// closest_fraction_search
// Nearest fraction a/b to target_num/target_den with 1 <= b <= den_limit.
// Walks the denominators until an exact match, keeping floor(num*b/den) and its
// remainder by adding num/den each step; one shared multiplier ranks candidates.
// ----------------------------------------------------------------------------
//  channel  direction  payload   handshake
//  query    in         query_t   query_valid / query_stall
//  result   out        result_t  result_valid / result_stall
//
//  a query with a zero numerator goes straight to the finish state, without a divide
//  otherwise: the initial divide (VW is VALUE_BITS capped at 16), then for each
//  denominator a step and, on the multiplier, an A and a B state per candidate
//  (no step after the last denominator), and finally the finish state;
//  the search stops early on an exact match
//  query_stall is high from acceptance until the result register is loaded
//  the result register holds while result_stall is high
//  reset clears the sequencer and the result valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module closest_fraction_search #(
	parameter int VALUE_BITS = cfs_pkg::VALUE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             query_valid,
	output logic                  query_stall,
	input  wire cfs_pkg::query_t  query,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output cfs_pkg::result_t      result
);

	// values are taken in their low bits, at most the field width
	localparam int VW = (VALUE_BITS < cfs_pkg::FIELD_BITS) ? VALUE_BITS
	                                                       : cfs_pkg::FIELD_BITS;
	localparam int QW = 2 * VW;

	cfs_pkg::state_t state_q, state_d;

	logic [VW-1:0] num_in, den_in, lim_in;
	logic [VW-1:0] den_q, lim_q, b_q;
	logic [VW-1:0] qn_q, rn_q, r_q;
	logic [QW-1:0] q_q;
	logic [QW-1:0] best_a_q;
	logic [VW-1:0] best_b_q, best_d_q;
	logic          have_q;
	logic [QW-1:0] p1_q;
	logic          res_valid_q;
	cfs_pkg::result_t res_q;

	logic          accept;
	logic          div_start, div_done;
	logic [VW-1:0] div_quo, div_rem;
	logic          is_lo;
	logic [QW-1:0] cand_a;
	logic [VW-1:0] cand_d;
	logic [VW-1:0] mul_x, mul_y;
	logic [QW-1:0] prod;
	logic          take;
	logic [VW:0]   r_sum;
	logic          wrap;
	logic [VW-1:0] r_next;
	logic [QW-1:0] q_next;
	logic          load_res;
	logic          out_free;

	// request decode, zero denominator and zero limit read as one
	assign num_in = query.target_num[VW-1:0];
	assign den_in = (query.target_den[VW-1:0] == '0) ? VW'(1) : query.target_den[VW-1:0];
	assign lim_in = (query.den_limit[VW-1:0] == '0) ? VW'(1) : query.den_limit[VW-1:0];
	assign accept = query_valid && !query_stall;

	// initial num / den, stepped afterwards by additions
	cfs_div #(.W(VW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (num_in),
		.divisor   (den_in),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// current candidate: a = q with distance r, or a = q+1 with distance den-r
	assign is_lo  = (state_q == cfs_pkg::ST_LO_A) || (state_q == cfs_pkg::ST_LO_B);
	assign cand_a = is_lo ? q_q : q_q + QW'(1);
	assign cand_d = is_lo ? r_q : den_q - r_q;

	// shared multiplier: cand_d*best_b first, then best_d*b
	always_comb begin
		case (state_q)
			cfs_pkg::ST_LO_A, cfs_pkg::ST_HI_A: begin
				mul_x = cand_d;
				mul_y = best_b_q;
			end
			default: begin
				mul_x = best_d_q;
				mul_y = b_q;
			end
		endcase
	end
	assign prod = QW'(mul_x) * QW'(mul_y);
	assign take = !have_q || (p1_q < prod);

	// next denominator: add num/den to q, r and fold the remainder
	assign r_sum  = {1'b0, r_q} + {1'b0, rn_q};
	assign wrap   = r_sum >= {1'b0, den_q};
	assign r_next = wrap ? VW'(r_sum - {1'b0, den_q}) : r_sum[VW-1:0];
	assign q_next = q_q + QW'(qn_q) + QW'(wrap);

	assign out_free = !res_valid_q || !result_stall;

	// next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		load_res  = 1'b0;
		case (state_q)
			cfs_pkg::ST_IDLE: begin
				if (query_valid) begin
					if (num_in == '0) begin
						state_d = cfs_pkg::ST_FINISH;
					end else begin
						div_start = 1'b1;
						state_d   = cfs_pkg::ST_DIV;
					end
				end
			end
			cfs_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = (div_quo != '0) ? cfs_pkg::ST_LO_A : cfs_pkg::ST_HI_A;
				end
			end
			cfs_pkg::ST_LO_A: state_d = cfs_pkg::ST_LO_B;
			cfs_pkg::ST_LO_B: begin
				state_d = (take && cand_d == '0) ? cfs_pkg::ST_FINISH : cfs_pkg::ST_HI_A;
			end
			cfs_pkg::ST_HI_A: state_d = cfs_pkg::ST_HI_B;
			cfs_pkg::ST_HI_B: begin
				if ((take && cand_d == '0) || b_q == lim_q) begin
					state_d = cfs_pkg::ST_FINISH;
				end else begin
					state_d = cfs_pkg::ST_STEP;
				end
			end
			cfs_pkg::ST_STEP: begin
				state_d = (q_next != '0) ? cfs_pkg::ST_LO_A : cfs_pkg::ST_HI_A;
			end
			cfs_pkg::ST_FINISH: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = cfs_pkg::ST_IDLE;
				end
			end
			default: state_d = cfs_pkg::ST_IDLE;
		endcase
	end

	// state register and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfs_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
			have_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				have_q <= 1'b0;
			end else if ((state_q == cfs_pkg::ST_LO_B || state_q == cfs_pkg::ST_HI_B)
			             && take) begin
				have_q <= 1'b1;
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			cfs_pkg::ST_IDLE: begin
				den_q    <= den_in;
				lim_q    <= lim_in;
				b_q      <= VW'(1);
				best_a_q <= '0;
				best_b_q <= VW'(1);
				best_d_q <= '0;
			end
			cfs_pkg::ST_DIV: begin
				qn_q <= div_quo;
				rn_q <= div_rem;
				q_q  <= QW'(div_quo);
				r_q  <= div_rem;
			end
			cfs_pkg::ST_LO_A, cfs_pkg::ST_HI_A: begin
				p1_q <= prod;
			end
			cfs_pkg::ST_LO_B, cfs_pkg::ST_HI_B: begin
				if (take) begin
					best_a_q <= cand_a;
					best_b_q <= b_q;
					best_d_q <= cand_d;
				end
			end
			cfs_pkg::ST_STEP: begin
				q_q <= q_next;
				r_q <= r_next;
				b_q <= b_q + VW'(1);
			end
			default: begin
			end
		endcase
		if (load_res) begin
			res_q.best_num <= cfs_pkg::NUM_OUT_BITS'(best_a_q);
			res_q.best_den <= cfs_pkg::FIELD_BITS'(best_b_q);
		end
	end

	assign query_stall  = (state_q != cfs_pkg::ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// checks
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.best_den != '0))
		else $error("result denominator is zero");

	a_best_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(have_q && state_q != cfs_pkg::ST_IDLE) |-> (best_b_q <= lim_q))
		else $error("best denominator beyond limit");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cfs_pkg::ST_STEP || state_q == cfs_pkg::ST_HI_A
		 || state_q == cfs_pkg::ST_LO_A) |-> (r_q < den_q))
		else $error("running remainder not reduced");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cfs_pkg::ST_FINISH && !(res_valid_q && result_stall))
		|=> (result_valid && state_q == cfs_pkg::ST_IDLE))
		else $error("finished search did not reach the result register");

endmodule

`default_nettype wire

@@ rtl/cfs_div.sv @@
// ----------------------------------------------------------------------------
// cfs_div
// Restoring divider, one quotient bit per cycle. After start it forms W quotient bits
// and pulses done for one cycle with quotient and remainder valid.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_div #(
	parameter int W = cfs_pkg::VALUE_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dvs_q;
	logic [W-1:0]  rem_q;
	logic [W:0]    rem_sh;
	logic          fits;

	// shift in the next dividend bit and trial subtract
	assign rem_sh = {rem_q, dvd_q[W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits fill the dividend register from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], fits};
			rem_q <= fits ? W'(rem_sh - {1'b0, dvs_q}) : rem_sh[W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire
